>>> rtl/core/dwip_pkg.sv
// shared widths, constants and types for the dual wheel incremental pid block
package dwip_pkg;

    localparam int SPEED_W    = 16;
    localparam int LIMIT_W    = 14;
    localparam int GAIN_W     = 18;
    localparam int DRIVE_W    = 15;
    localparam int CNT_W      = 8;
    localparam int DIST_W     = 32;
    localparam int ERR_W      = 17;
    localparam int ACC_W      = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int ERROR_LIMIT = 1000;

    localparam logic signed [DIST_W-1:0] BAND_HALF = 32'sd25600;
    localparam logic signed [DIST_W-1:0] BAND_ONE  = 32'sd51200;
    localparam logic signed [DIST_W-1:0] BAND_TWO  = 32'sd102400;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 14'd8000;
    localparam logic [LIMIT_W-1:0] LIMIT_START    = 14'd10000;
    localparam logic [LIMIT_W-1:0] LIMIT_BAND_ONE = 14'd4000;
    localparam logic [LIMIT_W-1:0] LIMIT_RING     = 14'd6000;
    localparam logic [LIMIT_W-1:0] LIMIT_LOST     = 14'd5000;
    localparam logic [LIMIT_W-1:0] LIMIT_STEP     = 14'd100;
    localparam logic [LIMIT_W-1:0] LIMIT_LOST_MAX = 14'd6000;

    localparam logic [GAIN_W-1:0] KP_1000 = 18'd256000;
    localparam logic [GAIN_W-1:0] KP_900  = 18'd230400;
    localparam logic [GAIN_W-1:0] KP_250  = 18'd64000;

    localparam logic signed [SPEED_W-1:0] TARGET_RING = 16'sd563;
    localparam logic signed [SPEED_W-1:0] TARGET_LOST = 16'sd512;
    localparam logic signed [SPEED_W-1:0] TARGET_STOP = 16'sd0;

    localparam logic [CNT_W-1:0] FOLD_MIN   = 8'd5;
    localparam logic [CNT_W-1:0] LOST_SHORT = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_SPEED    = 3'd0,
        REG_BASE_OUT_LIMIT  = 3'd1,
        REG_KP_LEFT_NORMAL  = 3'd2,
        REG_KP_RIGHT_NORMAL = 3'd3,
        REG_KI_LEFT         = 3'd4,
        REG_KI_RIGHT        = 3'd5,
        REG_KD_LEFT         = 3'd6,
        REG_KD_RIGHT        = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target;
        logic [LIMIT_W-1:0]        limit;
        logic signed [SPEED_W-1:0] speed_l;
        logic signed [SPEED_W-1:0] speed_r;
        logic [GAIN_W-1:0]         kp_l;
        logic [GAIN_W-1:0]         kp_r;
    } mode_t;

    typedef struct packed {
        logic ld_e;
        logic ld_p;
        logic ld_s;
        logic ld_o;
    } pipe_ctl_t;

endpackage

>>> rtl/core/dwip_if.sv
// stream interfaces for control tick beats and drive result beats
interface dwip_in_if;
    import dwip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      distance_enable;
    logic                      in_ring;
    logic                      out_ring;
    logic                      line_lost;
    logic [CNT_W-1:0]          lost_count;
    logic [CNT_W-1:0]          bend_count;

    modport source (
        output valid, left_speed, right_speed, distance_enable, in_ring, out_ring,
               line_lost, lost_count, bend_count,
        input  ready
    );

    modport sink (
        input  valid, left_speed, right_speed, distance_enable, in_ring, out_ring,
               line_lost, lost_count, bend_count,
        output ready
    );
endinterface

interface dwip_out_if;
    import dwip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;

    modport source (
        output valid, left_drive, right_drive,
        input  ready
    );

    modport sink (
        input  valid, left_drive, right_drive,
        output ready
    );
endinterface

>>> rtl/core/dwip_mode.sv
// distance tracking and per tick mode, target, limit and gain selection
module dwip_mode (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ld_in,
    input  logic                                ld_mode,
    input  logic signed [dwip_pkg::SPEED_W-1:0] left_speed,
    input  logic signed [dwip_pkg::SPEED_W-1:0] right_speed,
    input  logic                                distance_enable,
    input  logic                                in_ring,
    input  logic                                out_ring,
    input  logic                                line_lost,
    input  logic [dwip_pkg::CNT_W-1:0]          lost_count,
    input  logic [dwip_pkg::CNT_W-1:0]          bend_count,
    input  logic signed [dwip_pkg::SPEED_W-1:0] target_speed,
    input  logic [dwip_pkg::LIMIT_W-1:0]        base_out_limit,
    input  logic [dwip_pkg::GAIN_W-1:0]         kp_left_normal,
    input  logic [dwip_pkg::GAIN_W-1:0]         kp_right_normal,
    output dwip_pkg::mode_t                     mode
);
    import dwip_pkg::*;

    logic signed [SPEED_W-1:0] speed_l_reg;
    logic signed [SPEED_W-1:0] speed_r_reg;
    logic                      ring_in_reg;
    logic                      ring_out_reg;
    logic                      lost_reg;
    logic [CNT_W-1:0]          lost_cnt_reg;
    logic [CNT_W-1:0]          folds_reg;

    logic signed [DIST_W-1:0]  distance_reg;
    logic signed [DIST_W-1:0]  distance_next;
    logic signed [DIST_W+1:0]  dist_sum;

    logic [GAIN_W-1:0]         kp_l_reg;
    logic [GAIN_W-1:0]         kp_r_reg;
    mode_t                     mode_reg;
    mode_t                     mode_next;
    logic [LIMIT_W:0]          limit_bump;

    // saturating travel sum
    always_comb
    begin
        dist_sum = (DIST_W+2)'(distance_reg) + (DIST_W+2)'(left_speed)
                 + (DIST_W+2)'(right_speed);
        if (dist_sum[DIST_W+1:DIST_W-1] == 3'b000 || dist_sum[DIST_W+1:DIST_W-1] == 3'b111)
        begin
            distance_next = dist_sum[DIST_W-1:0];
        end
        else if (dist_sum[DIST_W+1])
        begin
            distance_next = {1'b1, {(DIST_W-1){1'b0}}};
        end
        else
        begin
            distance_next = {1'b0, {(DIST_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        mode_next         = '0;
        mode_next.target  = target_speed;
        mode_next.limit   = base_out_limit;
        mode_next.speed_l = speed_l_reg;
        mode_next.speed_r = speed_r_reg;
        mode_next.kp_l    = kp_l_reg;
        mode_next.kp_r    = kp_r_reg;
        limit_bump        = '0;

        // start bands
        if (distance_reg <= BAND_TWO)
        begin
            if (distance_reg <= BAND_HALF)
            begin
                mode_next.limit = LIMIT_START;
                mode_next.kp_l  = KP_1000;
                mode_next.kp_r  = KP_1000;
            end
            else if (distance_reg <= BAND_ONE)
            begin
                mode_next.limit = LIMIT_BAND_ONE;
                mode_next.kp_l  = KP_250;
                mode_next.kp_r  = KP_250;
            end
            else
            begin
                mode_next.kp_l = kp_left_normal;
                mode_next.kp_r = kp_right_normal;
            end
        end

        if (!lost_reg)
        begin
            if (ring_in_reg && !ring_out_reg)
            begin
                mode_next.limit  = LIMIT_RING;
                mode_next.target = TARGET_RING;
                mode_next.kp_l   = KP_250;
                mode_next.kp_r   = KP_250;
            end
            else if (folds_reg >= FOLD_MIN)
            begin
                mode_next.kp_l = KP_900;
                mode_next.kp_r = KP_900;
            end
        end
        else if (lost_cnt_reg <= LOST_SHORT)
        begin
            mode_next.limit  = LIMIT_LOST;
            mode_next.target = TARGET_STOP;
            mode_next.kp_l   = KP_250;
            mode_next.kp_r   = KP_250;
        end
        else
        begin
            limit_bump = {1'b0, mode_next.limit} + {1'b0, LIMIT_STEP};
            if (limit_bump > {1'b0, LIMIT_LOST_MAX})
            begin
                mode_next.limit = LIMIT_LOST_MAX;
            end
            else
            begin
                mode_next.limit = limit_bump[LIMIT_W-1:0];
            end
            mode_next.target = TARGET_LOST;
            mode_next.kp_l   = KP_250;
            mode_next.kp_r   = KP_250;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_reg <= '0;
            kp_l_reg     <= '0;
            kp_r_reg     <= '0;
        end
        else
        begin
            if (ld_in && distance_enable)
            begin
                distance_reg <= distance_next;
            end
            if (ld_mode)
            begin
                kp_l_reg <= mode_next.kp_l;
                kp_r_reg <= mode_next.kp_r;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_in)
        begin
            speed_l_reg  <= left_speed;
            speed_r_reg  <= right_speed;
            ring_in_reg  <= in_ring;
            ring_out_reg <= out_ring;
            lost_reg     <= line_lost;
            lost_cnt_reg <= lost_count;
            folds_reg    <= bend_count;
        end
        if (ld_mode)
        begin
            mode_reg <= mode_next;
        end
    end

    assign mode = mode_reg;

endmodule

>>> rtl/core/dwip_lane.sv
// one wheel lane: error clamp, pid products, sum and clamped accumulator
module dwip_lane #(
    parameter int ERROR_LIMIT = dwip_pkg::ERROR_LIMIT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dwip_pkg::pipe_ctl_t                 ctl,
    input  logic signed [dwip_pkg::SPEED_W-1:0] target,
    input  logic signed [dwip_pkg::SPEED_W-1:0] speed,
    input  logic [dwip_pkg::LIMIT_W-1:0]        limit,
    input  logic [dwip_pkg::GAIN_W-1:0]         kp,
    input  logic [dwip_pkg::GAIN_W-1:0]         ki,
    input  logic [dwip_pkg::GAIN_W-1:0]         kd,
    output logic signed [dwip_pkg::DRIVE_W-1:0] drive
);
    import dwip_pkg::*;

    localparam int DIFF_W = 20;
    localparam int PP_W   = GAIN_W + 1 + ERR_W + 1;
    localparam int PI_W   = GAIN_W + 1 + ERR_W;
    localparam int PD_W   = GAIN_W + 1 + ERR_W + 2;
    localparam int SUM_W  = PD_W + 1;
    localparam int DU_W   = SUM_W - 8;
    localparam int ACCS_W = DU_W + 1;
    localparam logic signed [DIFF_W-1:0] ELIM = DIFF_W'(ERROR_LIMIT * 256);

    // error stage
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] diff_clamped;
    logic signed [ERR_W-1:0]  e0_reg;
    logic [GAIN_W-1:0]        kp_e_reg;
    logic [LIMIT_W-1:0]       limit_e_reg;

    // product stage
    logic signed [ERR_W-1:0]  e1_reg;
    logic signed [ERR_W-1:0]  e2_reg;
    logic signed [GAIN_W:0]   kp_s;
    logic signed [GAIN_W:0]   ki_s;
    logic signed [GAIN_W:0]   kd_s;
    logic signed [ERR_W:0]    dp;
    logic signed [ERR_W+1:0]  dd;
    logic signed [PP_W-1:0]   pp_reg;
    logic signed [PI_W-1:0]   pi_reg;
    logic signed [PD_W-1:0]   pd_reg;
    logic [LIMIT_W-1:0]       limit_p_reg;

    // sum stage
    logic signed [SUM_W-1:0]  du_full;
    logic signed [DU_W-1:0]   du_reg;
    logic [LIMIT_W-1:0]       limit_s_reg;

    // accumulate stage
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACCS_W-1:0] acc_sum;
    logic signed [ACCS_W-1:0] lim;
    logic signed [ACC_W:0]    acc_adj;

    always_comb
    begin
        diff = DIFF_W'(target) - DIFF_W'(speed);
        if (diff > ELIM)
        begin
            diff_clamped = ELIM;
        end
        else if (diff < -ELIM)
        begin
            diff_clamped = -ELIM;
        end
        else
        begin
            diff_clamped = diff;
        end
    end

    assign kp_s = signed'({1'b0, kp_e_reg});
    assign ki_s = signed'({1'b0, ki});
    assign kd_s = signed'({1'b0, kd});
    assign dp   = (ERR_W+1)'(e0_reg) - (ERR_W+1)'(e1_reg);
    assign dd   = (ERR_W+2)'(e0_reg) - ((ERR_W+2)'(e1_reg) <<< 1) + (ERR_W+2)'(e2_reg);

    // floor to q.8 is an arithmetic shift
    assign du_full = SUM_W'(pp_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);

    always_comb
    begin
        acc_sum = ACCS_W'(acc_reg) + ACCS_W'(du_reg);
        lim     = signed'(ACCS_W'({limit_s_reg, 8'b0}));
        if (acc_sum > lim)
        begin
            acc_next = lim[ACC_W-1:0];
        end
        else if (acc_sum < -lim)
        begin
            acc_next = ACC_W'(-lim);
        end
        else
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
        // truncate toward zero
        acc_adj = (ACC_W+1)'(acc_next) + (acc_next[ACC_W-1] ? (ACC_W+1)'(255) : '0);
        drive   = acc_adj[ACC_W-1:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg  <= '0;
            e2_reg  <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (ctl.ld_p)
            begin
                e1_reg <= e0_reg;
                e2_reg <= e1_reg;
            end
            if (ctl.ld_o)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_e)
        begin
            e0_reg      <= diff_clamped[ERR_W-1:0];
            kp_e_reg    <= kp;
            limit_e_reg <= limit;
        end
        if (ctl.ld_p)
        begin
            pp_reg      <= PP_W'(kp_s * dp);
            pi_reg      <= PI_W'(ki_s * e0_reg);
            pd_reg      <= PD_W'(kd_s * dd);
            limit_p_reg <= limit_e_reg;
        end
        if (ctl.ld_s)
        begin
            du_reg      <= du_full[SUM_W-1:8];
            limit_s_reg <= limit_p_reg;
        end
    end

endmodule

>>> rtl/core/dual_wheel_incremental_pid_top.sv
// top level: config registers, pipeline control, two wheel lanes and result merge
//
//   port      dir  kind            payload
//   item      in   valid/ready     speeds, distance enable, ring/lost flags, counts
//   result    out  valid/ready     left_drive, right_drive
//   cfg_*     in   write only      cfg_index selects one of eight registers
//
// six register stages from accepted beat to result beat; one beat per cycle while result is ready
// per-wheel state is read and written within a single stage, so beats follow back to back
// reset clears all valid flags, distance, gains, accumulators and error history
// empty stages close up under a stalled result, so item stays ready until all stages hold a beat
module dual_wheel_incremental_pid_top #(
    parameter int ERROR_LIMIT = dwip_pkg::ERROR_LIMIT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    dwip_in_if.sink                                item,
    dwip_out_if.source                             result,
    input  logic                                   cfg_we,
    input  logic [dwip_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dwip_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import dwip_pkg::*;

    logic signed [SPEED_W-1:0] target_speed_reg;
    logic [LIMIT_W-1:0]        base_out_limit_reg;
    logic [GAIN_W-1:0]         kp_left_normal_reg;
    logic [GAIN_W-1:0]         kp_right_normal_reg;
    logic [GAIN_W-1:0]         ki_left_reg;
    logic [GAIN_W-1:0]         ki_right_reg;
    logic [GAIN_W-1:0]         kd_left_reg;
    logic [GAIN_W-1:0]         kd_right_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;
    logic ld1, ld2;
    pipe_ctl_t ctl;
    mode_t     mode;

    logic signed [DRIVE_W-1:0] left_next;
    logic signed [DRIVE_W-1:0] right_next;
    logic signed [DRIVE_W-1:0] left_drive_reg;
    logic signed [DRIVE_W-1:0] right_drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg    <= '0;
            base_out_limit_reg  <= LIMIT_RESET;
            kp_left_normal_reg  <= '0;
            kp_right_normal_reg <= '0;
            ki_left_reg         <= '0;
            ki_right_reg        <= '0;
            kd_left_reg         <= '0;
            kd_right_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TARGET_SPEED:    target_speed_reg    <= signed'(cfg_data[SPEED_W-1:0]);
                REG_BASE_OUT_LIMIT:  base_out_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_KP_LEFT_NORMAL:  kp_left_normal_reg  <= cfg_data[GAIN_W-1:0];
                REG_KP_RIGHT_NORMAL: kp_right_normal_reg <= cfg_data[GAIN_W-1:0];
                REG_KI_LEFT:         ki_left_reg         <= cfg_data[GAIN_W-1:0];
                REG_KI_RIGHT:        ki_right_reg        <= cfg_data[GAIN_W-1:0];
                REG_KD_LEFT:         kd_left_reg         <= cfg_data[GAIN_W-1:0];
                REG_KD_RIGHT:        kd_right_reg        <= cfg_data[GAIN_W-1:0];
                default:             ;
            endcase
        end
    end

    // a stage moves when it is empty or the next one moves
    assign en6 = !v6_reg || result.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign item.ready = en1;
    assign ld1        = item.valid && en1;
    assign ld2        = v1_reg && en2;
    assign ctl.ld_e   = v2_reg && en3;
    assign ctl.ld_p   = v3_reg && en4;
    assign ctl.ld_s   = v4_reg && en5;
    assign ctl.ld_o   = v5_reg && en6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= item.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    dwip_mode u_mode (
        .clk             (clk),
        .rst_n           (rst_n),
        .ld_in           (ld1),
        .ld_mode         (ld2),
        .left_speed      (item.left_speed),
        .right_speed     (item.right_speed),
        .distance_enable (item.distance_enable),
        .in_ring         (item.in_ring),
        .out_ring        (item.out_ring),
        .line_lost       (item.line_lost),
        .lost_count      (item.lost_count),
        .bend_count      (item.bend_count),
        .target_speed    (target_speed_reg),
        .base_out_limit  (base_out_limit_reg),
        .kp_left_normal  (kp_left_normal_reg),
        .kp_right_normal (kp_right_normal_reg),
        .mode            (mode)
    );

    dwip_lane #(
        .ERROR_LIMIT (ERROR_LIMIT)
    ) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .target (mode.target),
        .speed  (mode.speed_l),
        .limit  (mode.limit),
        .kp     (mode.kp_l),
        .ki     (ki_left_reg),
        .kd     (kd_left_reg),
        .drive  (left_next)
    );

    dwip_lane #(
        .ERROR_LIMIT (ERROR_LIMIT)
    ) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .target (mode.target),
        .speed  (mode.speed_r),
        .limit  (mode.limit),
        .kp     (mode.kp_r),
        .ki     (ki_right_reg),
        .kd     (kd_right_reg),
        .drive  (right_next)
    );

    // merge both lanes into one result beat
    always_ff @(posedge clk)
    begin
        if (ctl.ld_o)
        begin
            left_drive_reg  <= left_next;
            right_drive_reg <= right_next;
        end
    end

    assign result.valid       = v6_reg;
    assign result.left_drive  = left_drive_reg;
    assign result.right_drive = right_drive_reg;

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !item.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg)
    ) else $error("item stalled with an empty stage");

    a_result_from_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(v5_reg)
    ) else $error("result beat without a beat in the last lane stage");

    a_result_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !v5_reg) |=> !result.valid
    ) else $error("result beat repeated after it was taken");
`endif

endmodule
